[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// A condition that must be followed by another in the next cycle.
`define ASSERT_NEXT(lbl, pre, post, clk, rstn) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

// A check that also runs while reset is asserted.
`define ASSERT_NORST(lbl, prop, clk) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

[rtl/core/pgcb_pkg.sv]
package pgcb_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned InvW     = 32;
  localparam int unsigned IdW      = 20;
  localparam int unsigned CntW     = 11;
  localparam int unsigned CellW    = 10;
  localparam int unsigned BucketW  = 30;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned RowW     = 2 * CntW + 1;

  localparam int unsigned MaxCellsPerAxisDef = 1024;

  localparam logic [CfgIdxW-1:0] RegGridMinX  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegGridMinY  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegGridMinZ  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegInvCell   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCellsX    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegCellsY    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegCellsZ    = 3'd6;

  localparam logic [InvW-1:0] InvCellReset = 32'd65536;
  localparam logic [CntW-1:0] CellsReset   = 11'd1;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } adv_t;

endpackage

[rtl/core/pgcb_if.sv]
interface pgcb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pgcb_pkg::CfgIdxW-1:0]     index;
  logic [pgcb_pkg::CfgDataW-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface pgcb_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [pgcb_pkg::PosW-1:0] pos_x;
  logic signed [pgcb_pkg::PosW-1:0] pos_y;
  logic signed [pgcb_pkg::PosW-1:0] pos_z;
  logic [pgcb_pkg::IdW-1:0]         particle_id;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output particle_id, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input particle_id, output ready);
endinterface

interface pgcb_out_if;
  logic                             valid;
  logic                             ready;
  logic [pgcb_pkg::IdW-1:0]         particle_num;
  logic [pgcb_pkg::BucketW-1:0]     bucket_index;
  logic [pgcb_pkg::CellW-1:0]       cell_x;
  logic [pgcb_pkg::CellW-1:0]       cell_y;
  logic [pgcb_pkg::CellW-1:0]       cell_z;

  modport source (output valid, output particle_num, output bucket_index,
                  output cell_x, output cell_y, output cell_z, input ready);
  modport sink (input valid, input particle_num, input bucket_index,
                input cell_x, input cell_y, input cell_z, output ready);
endinterface

[rtl/core/particle_grid_cell_binning.sv]
// Uniform grid binning of a particle stream.
// Input channel in_i carries one particle per word: a signed Q16.16 position
// and the particle index. Output channel out_o carries the index, the three
// cell coordinates and the flattened bucket index (x fastest, then y, then z).
// A particle whose cell lies outside the grid on any axis produces no word.
// Channel cfg_i writes the grid corner, the reciprocal cell edge and the cell
// counts; it is always ready and must be written only while no particle is
// in flight.
// The datapath is a five stage pipeline: offset, multiply by the reciprocal,
// floor and range check, then two multiply-add stages for the bucket index.
// One particle is accepted every cycle while a stage can take it; each stage
// has its own valid bit and fills a bubble even while the output is stalled,
// so input stops only when all five stages hold a word.
// Reset clears the valid bits and loads the register defaults: corner at the
// origin, unit cells, one cell per axis.
module particle_grid_cell_binning #(
  parameter int unsigned MaxCellsPerAxis = pgcb_pkg::MaxCellsPerAxisDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pgcb_cfg_if.sink    cfg_i,
  pgcb_in_if.sink     in_i,
  pgcb_out_if.source  out_o
);

  localparam int unsigned NumStages = 5;
  localparam logic [16:0] MaxCells  = 17'(MaxCellsPerAxis);

  logic signed [pgcb_pkg::PosW-1:0] min_x_q;
  logic signed [pgcb_pkg::PosW-1:0] min_y_q;
  logic signed [pgcb_pkg::PosW-1:0] min_z_q;
  logic [pgcb_pkg::InvW-1:0]        inv_q;
  logic [pgcb_pkg::CntW-1:0]        cells_x_q;
  logic [pgcb_pkg::CntW-1:0]        cells_y_q;
  logic [pgcb_pkg::CntW-1:0]        cells_z_q;
  logic [pgcb_pkg::CntW-1:0]        nx;
  logic [pgcb_pkg::CntW-1:0]        ny;
  logic [pgcb_pkg::CntW-1:0]        nz;

  logic [NumStages-1:0]             vld_q;
  logic [NumStages-1:0]             adv;
  pgcb_pkg::adv_t                   axis_adv;

  logic [pgcb_pkg::IdW-1:0]         id1_q;
  logic [pgcb_pkg::IdW-1:0]         id2_q;
  logic [pgcb_pkg::IdW-1:0]         id3_q;
  logic [pgcb_pkg::IdW-1:0]         id4_q;
  logic [pgcb_pkg::IdW-1:0]         id5_q;

  logic [pgcb_pkg::CntW-1:0]        cx3;
  logic [pgcb_pkg::CntW-1:0]        cy3;
  logic [pgcb_pkg::CntW-1:0]        cz3;
  logic                             okx3;
  logic                             oky3;
  logic                             okz3;

  logic [pgcb_pkg::RowW-1:0]        row_d;
  logic [pgcb_pkg::RowW-1:0]        row_q;
  logic [pgcb_pkg::CntW-1:0]        cx4_q;
  logic [pgcb_pkg::CntW-1:0]        cy4_q;
  logic [pgcb_pkg::CntW-1:0]        cz4_q;

  logic [pgcb_pkg::RowW+pgcb_pkg::CntW-1:0] bucket_d;
  logic [pgcb_pkg::BucketW-1:0]     bucket_q;
  logic [pgcb_pkg::CellW-1:0]       cx5_q;
  logic [pgcb_pkg::CellW-1:0]       cy5_q;
  logic [pgcb_pkg::CellW-1:0]       cz5_q;

  function automatic logic [pgcb_pkg::CntW-1:0] clip_count(
    input logic [pgcb_pkg::CntW-1:0] c
  );
    logic [16:0] wide;
    wide = 17'(c);
    return (wide > MaxCells) ? MaxCells[pgcb_pkg::CntW-1:0] : c;
  endfunction

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q   <= '0;
      min_y_q   <= '0;
      min_z_q   <= '0;
      inv_q     <= pgcb_pkg::InvCellReset;
      cells_x_q <= pgcb_pkg::CellsReset;
      cells_y_q <= pgcb_pkg::CellsReset;
      cells_z_q <= pgcb_pkg::CellsReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        pgcb_pkg::RegGridMinX: min_x_q   <= cfg_i.data;
        pgcb_pkg::RegGridMinY: min_y_q   <= cfg_i.data;
        pgcb_pkg::RegGridMinZ: min_z_q   <= cfg_i.data;
        pgcb_pkg::RegInvCell:  inv_q     <= cfg_i.data;
        pgcb_pkg::RegCellsX:   cells_x_q <= cfg_i.data[pgcb_pkg::CntW-1:0];
        pgcb_pkg::RegCellsY:   cells_y_q <= cfg_i.data[pgcb_pkg::CntW-1:0];
        pgcb_pkg::RegCellsZ:   cells_z_q <= cfg_i.data[pgcb_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  assign nx = clip_count(cells_x_q);
  assign ny = clip_count(cells_y_q);
  assign nz = clip_count(cells_z_q);

  // A stage takes a new word when it is empty or its word moves on.
  always_comb begin
    adv[NumStages-1] = !vld_q[NumStages-1] || out_o.ready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign axis_adv = '{s1: adv[0], s2: adv[1], s3: adv[2]};
  assign in_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) begin
        vld_q[0] <= in_i.valid;
      end
      if (adv[1]) begin
        vld_q[1] <= vld_q[0];
      end
      if (adv[2]) begin
        vld_q[2] <= vld_q[1];
      end
      if (adv[3]) begin
        vld_q[3] <= vld_q[2] && okx3 && oky3 && okz3;
      end
      if (adv[4]) begin
        vld_q[4] <= vld_q[3];
      end
    end
  end

  pgcb_axis u_axis_x (
    .clk_i   (clk_i),
    .adv_i   (axis_adv),
    .pos_i   (in_i.pos_x),
    .lo_i    (min_x_q),
    .inv_i   (inv_q),
    .count_i (nx),
    .cell_o  (cx3),
    .ok_o    (okx3)
  );

  pgcb_axis u_axis_y (
    .clk_i   (clk_i),
    .adv_i   (axis_adv),
    .pos_i   (in_i.pos_y),
    .lo_i    (min_y_q),
    .inv_i   (inv_q),
    .count_i (ny),
    .cell_o  (cy3),
    .ok_o    (oky3)
  );

  pgcb_axis u_axis_z (
    .clk_i   (clk_i),
    .adv_i   (axis_adv),
    .pos_i   (in_i.pos_z),
    .lo_i    (min_z_q),
    .inv_i   (inv_q),
    .count_i (nz),
    .cell_o  (cz3),
    .ok_o    (okz3)
  );

  assign row_d = pgcb_pkg::RowW'(cz3) * pgcb_pkg::RowW'(ny) + pgcb_pkg::RowW'(cy3);
  assign bucket_d = (pgcb_pkg::RowW + pgcb_pkg::CntW)'(row_q)
                  * (pgcb_pkg::RowW + pgcb_pkg::CntW)'(nx)
                  + (pgcb_pkg::RowW + pgcb_pkg::CntW)'(cx4_q);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      id1_q <= in_i.particle_id;
    end
    if (adv[1]) begin
      id2_q <= id1_q;
    end
    if (adv[2]) begin
      id3_q <= id2_q;
    end
    if (adv[3]) begin
      id4_q <= id3_q;
      row_q <= row_d;
      cx4_q <= cx3;
      cy4_q <= cy3;
      cz4_q <= cz3;
    end
    if (adv[4]) begin
      id5_q    <= id4_q;
      bucket_q <= bucket_d[pgcb_pkg::BucketW-1:0];
      cx5_q    <= cx4_q[pgcb_pkg::CellW-1:0];
      cy5_q    <= cy4_q[pgcb_pkg::CellW-1:0];
      cz5_q    <= cz4_q[pgcb_pkg::CellW-1:0];
    end
  end

  assign out_o.valid        = vld_q[NumStages-1];
  assign out_o.particle_num = id5_q;
  assign out_o.bucket_index = bucket_q;
  assign out_o.cell_x       = cx5_q;
  assign out_o.cell_y       = cy5_q;
  assign out_o.cell_z       = cz5_q;

endmodule

[rtl/core/pgcb_axis.sv]
module pgcb_axis (
  input  logic                              clk_i,
  input  pgcb_pkg::adv_t                    adv_i,
  input  logic signed [pgcb_pkg::PosW-1:0]  pos_i,
  input  logic signed [pgcb_pkg::PosW-1:0]  lo_i,
  input  logic [pgcb_pkg::InvW-1:0]         inv_i,
  input  logic [pgcb_pkg::CntW-1:0]         count_i,
  output logic [pgcb_pkg::CntW-1:0]         cell_o,
  output logic                              ok_o
);

  logic [pgcb_pkg::PosW:0]        pos_ext;
  logic [pgcb_pkg::PosW:0]        lo_ext;
  logic                           below;
  logic [pgcb_pkg::PosW:0]        mag_d;
  logic [pgcb_pkg::PosW:0]        mag_q;
  logic                           neg1_q;
  logic [pgcb_pkg::ProdW-1:0]     prod_d;
  logic [pgcb_pkg::ProdW-1:0]     prod_q;
  logic                           neg2_q;
  logic [pgcb_pkg::ProdW-33:0]    whole;
  logic                           ok_d;
  logic [pgcb_pkg::CntW-1:0]      cell_d;
  logic [pgcb_pkg::CntW-1:0]      cell_q;
  logic                           ok_q;

  // The magnitude of the offset from the grid corner is formed at 33 bits.
  always_comb begin
    pos_ext = {pos_i[pgcb_pkg::PosW-1], pos_i};
    lo_ext  = {lo_i[pgcb_pkg::PosW-1], lo_i};
    below   = pos_i < lo_i;
    mag_d   = below ? (lo_ext - pos_ext) : (pos_ext - lo_ext);
  end

  assign prod_d = pgcb_pkg::ProdW'(mag_q) * pgcb_pkg::ProdW'(inv_i);

  // A position below the corner lands in cell zero only when the product vanishes.
  always_comb begin
    whole = prod_q[pgcb_pkg::ProdW-1:32];
    if (neg2_q) begin
      ok_d   = (prod_q == '0) && (count_i != '0);
      cell_d = '0;
    end else begin
      ok_d   = (whole < (pgcb_pkg::ProdW-32)'(count_i));
      cell_d = whole[pgcb_pkg::CntW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.s1) begin
      mag_q  <= mag_d;
      neg1_q <= below;
    end
    if (adv_i.s2) begin
      prod_q <= prod_d;
      neg2_q <= neg1_q;
    end
    if (adv_i.s3) begin
      cell_q <= cell_d;
      ok_q   <= ok_d;
    end
  end

  assign cell_o = cell_q;
  assign ok_o   = ok_q;

endmodule

[rtl/core/pgcb_checker.sv]
`include "assert_macros.svh"

module pgcb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_ready_i,
  input logic                            in_ready_i,
  input logic                            out_valid_i,
  input logic                            out_ready_i,
  input logic [pgcb_pkg::BucketW-1:0]    out_bucket_i,
  input logic [pgcb_pkg::IdW-1:0]        out_num_i
);

  // An empty output stage means the whole pipeline can take a word.
  `ASSERT_ALWAYS(a_ready_when_drained, !out_valid_i |-> in_ready_i, clk_i, rst_ni)

  `ASSERT_ALWAYS(a_cfg_always_ready, cfg_ready_i, clk_i, rst_ni)

  `ASSERT_NEXT(a_out_holds, out_valid_i && !out_ready_i,
    out_valid_i && $stable(out_bucket_i) && $stable(out_num_i), clk_i, rst_ni)

  // No word may leave in the cycle after reset was seen low.
  `ASSERT_NORST(a_reset_empties, !rst_ni |=> !out_valid_i, clk_i)

endmodule

bind particle_grid_cell_binning pgcb_checker u_pgcb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_i  (cfg_i.ready),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_bucket_i (out_o.bucket_index),
  .out_num_i    (out_o.particle_num)
);
